// ===== src/pcmp_pkg.sv =====
// ----------------------------------------------------------------------------
// pcmp_pkg
// shared constants and types of the bounded-part partition counter
// ----------------------------------------------------------------------------
package pcmp_pkg;

  // largest total the ways table can hold
  localparam int MAX_TOTAL = 127;
  // width of a ways table entry and of the result
  localparam int COUNT_W   = 42;
  // width of the input fields
  localparam int IN_W      = 7;
  localparam int DEPTH     = MAX_TOTAL + 1;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // read request into the ways table
  typedef struct packed {
    logic              en;
    logic              acc;     // accumulate: add b into a and write back to a
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } pcmp_rd_t;

  // clear write into the ways table
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic              one;     // write 1 instead of 0
  } pcmp_clr_t;

endpackage

// ===== src/pcmp_table.sv =====
// ----------------------------------------------------------------------------
// pcmp_table
// ways table memory with read-modify-write stage and write-to-read forwarding
// ----------------------------------------------------------------------------
module pcmp_table
  import pcmp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  pcmp_rd_t           rd,
  input  pcmp_clr_t          clr,
  output logic [COUNT_W-1:0] data_a
);

  logic [COUNT_W-1:0] mem [DEPTH];
  logic [COUNT_W-1:0] q_a_r;
  logic [COUNT_W-1:0] q_b_r;

  logic               s2_acc_r;
  logic [ADDR_W-1:0]  s2_addr_a_r;
  logic [ADDR_W-1:0]  s2_addr_b_r;

  // write that landed at the last edge
  logic               lw_vld_r;
  logic [ADDR_W-1:0]  lw_addr_r;
  logic [COUNT_W-1:0] lw_data_r;

  logic [COUNT_W-1:0] fwd_b;
  logic [COUNT_W-1:0] sum;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [COUNT_W-1:0] wr_data;

  // memory read data misses the write made at the same edge
  assign data_a = (lw_vld_r && lw_addr_r == s2_addr_a_r) ? lw_data_r : q_a_r;
  assign fwd_b  = (lw_vld_r && lw_addr_r == s2_addr_b_r) ? lw_data_r : q_b_r;
  assign sum    = data_a + fwd_b;

  always_comb begin
    wr_en   = clr.en || s2_acc_r;
    wr_addr = clr.en ? clr.addr : s2_addr_a_r;
    wr_data = clr.en ? COUNT_W'(clr.one) : sum;
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      q_a_r <= mem[rd.addr_a];
      q_b_r <= mem[rd.addr_b];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_acc_r <= 1'b0;
      lw_vld_r <= 1'b0;
    end else begin
      s2_acc_r <= rd.en && rd.acc;
      lw_vld_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      s2_addr_a_r <= rd.addr_a;
      s2_addr_b_r <= rd.addr_b;
    end
    lw_addr_r <= wr_addr;
    lw_data_r <= wr_data;
  end

endmodule

// ===== src/partition_count_max_part_core.sv =====
// ----------------------------------------------------------------------------
// partition_count_max_part_core
// counts partitions of a total into parts no larger than a given limit
// ----------------------------------------------------------------------------
// One item at a time. An accepted item first clears ways[0..total] (1 at
// entry 0, 0 elsewhere), then runs one read-modify-write of the ways table
// per cell, ways[i] += ways[i-j] for j in 1..limit and i in j..total, one
// cell per cycle through the dual-read table memory, where limit is
// max_part clamped to total. It then reads ways[total] into the result
// register; the single write port of the ways table sets the pace. A total
// above the table size gives count 0 at once. The result register lets the
// next item start while a count waits.
// ----------------------------------------------------------------------------
module partition_count_max_part_core
  import pcmp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [IN_W-1:0]    in_total,
  input  logic [IN_W-1:0]    in_max_part,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COUNT_W-1:0] out_count
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_CALC  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_RDRES = 3'd4;
  localparam logic [2:0] S_RES   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [ADDR_W-1:0]  tot_r, tot_nxt;     // total of the item in work
  logic [ADDR_W-1:0]  lim_r, lim_nxt;     // clamped part limit
  logic [ADDR_W-1:0]  i_r, i_nxt;         // table index
  logic [ADDR_W-1:0]  j_r, j_nxt;         // current part size
  logic [COUNT_W-1:0] res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  pcmp_rd_t           rd;
  pcmp_clr_t          clr;
  logic [COUNT_W-1:0] tbl_data;
  logic               in_acc;

  pcmp_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd     (rd),
    .clr    (clr),
    .data_a (tbl_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_count = out_count_r;

  always_comb begin
    state_nxt     = state_r;
    tot_nxt       = tot_r;
    lim_nxt       = lim_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    res_nxt       = res_r;
    out_count_nxt = out_count_r;
    // a waiting count leaves when taken
    out_valid_nxt = out_valid_r && out_stall;
    rd            = '0;
    clr           = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_total > IN_W'(MAX_TOTAL)) begin
            // too large for the table: count 0, table untouched
            res_nxt   = '0;
            state_nxt = S_FIN;
          end else begin
            tot_nxt   = in_total[ADDR_W-1:0];
            lim_nxt   = (in_max_part > in_total) ? in_total[ADDR_W-1:0]
                                                 : in_max_part[ADDR_W-1:0];
            i_nxt     = '0;
            state_nxt = S_CLEAR;
          end
        end
      end

      S_CLEAR: begin
        clr.en   = 1'b1;
        clr.addr = i_r;
        clr.one  = (i_r == '0);
        if (i_r == tot_r) begin
          if (lim_r == '0) begin
            // no parts allowed: the cleared entry is the answer
            state_nxt = S_RDRES;
          end else begin
            j_nxt     = ADDR_W'(1);
            i_nxt     = ADDR_W'(1);
            state_nxt = S_CALC;
          end
        end else begin
          i_nxt = i_r + ADDR_W'(1);
        end
      end

      S_CALC: begin
        // ways[i] += ways[i-j], written back in the following cycle
        rd.en     = 1'b1;
        rd.acc    = 1'b1;
        rd.addr_a = i_r;
        rd.addr_b = i_r - j_r;
        if (i_r == tot_r) begin
          if (j_r == lim_r) begin
            state_nxt = S_DRAIN;
          end else begin
            j_nxt = j_r + ADDR_W'(1);
            i_nxt = j_r + ADDR_W'(1);
          end
        end else begin
          i_nxt = i_r + ADDR_W'(1);
        end
      end

      S_DRAIN: begin
        // last cell is written back in this cycle
        state_nxt = S_RDRES;
      end

      S_RDRES: begin
        rd.en     = 1'b1;
        rd.addr_a = tot_r;
        rd.addr_b = tot_r;
        state_nxt = S_RES;
      end

      S_RES: begin
        res_nxt   = tbl_data;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        // hand over once the result register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tot_r       <= tot_nxt;
    lim_r       <= lim_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    res_r       <= res_nxt;
    out_count_r <= out_count_nxt;
  end

endmodule

// ===== src/pcmp_checker.sv =====
// ----------------------------------------------------------------------------
// pcmp_checker
// port-level checks of the partition counter, bound to the top level
// ----------------------------------------------------------------------------
module pcmp_checker
  import pcmp_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [COUNT_W-1:0] out_count
);

  // a held count stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_count))
    else $error("count changed while held");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // no count appears in the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("count appeared too early");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("count valid after reset");

endmodule

bind partition_count_max_part_core pcmp_checker u_pcmp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_count   (out_count)
);

// ===== test/pcmp_count_checker.sv =====
// ----------------------------------------------------------------------------
// pcmp_count_checker
// predicts the partition count of every accepted item and checks each result
// ----------------------------------------------------------------------------
module pcmp_count_checker
  import pcmp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [IN_W-1:0]    in_total,
  input  logic [IN_W-1:0]    in_max_part,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [COUNT_W-1:0] out_count,
  output int                 mismatches,
  output int                 pending,
  output int                 checked
);

  // private copy of the ways table
  logic [COUNT_W-1:0] ways_tbl [0:MAX_TOTAL];
  logic [COUNT_W-1:0] expected_counts [$];
  logic [COUNT_W-1:0] want;

  // ways[i] += ways[i-j] over part sizes j up to the clamped limit, wrapping at COUNT_W
  function automatic logic [COUNT_W-1:0] count_partitions(input logic [IN_W-1:0] total,
                                                          input logic [IN_W-1:0] max_part);
    int t;
    int lim;
    t = int'(total);
    lim = int'(max_part);
    if (t > MAX_TOTAL) return '0;
    if (lim > t) lim = t;
    ways_tbl[0] = COUNT_W'(1);
    for (int i = 1; i <= t; i++) ways_tbl[i] = '0;
    for (int j = 1; j <= lim; j++)
      for (int i = j; i <= t; i++)
        ways_tbl[i] = ways_tbl[i] + ways_tbl[i-j];
    return ways_tbl[t];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_counts.delete();
      pending <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_counts = {expected_counts, count_partitions(in_total, in_max_part)};
      if (out_valid && !out_stall) begin
        if (expected_counts.size() == 0) begin
          $error("count: no result expected, actual %0d", out_count);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_counts.pop_front();
          checked <= checked + 1;
          if (out_count !== want) begin
            $error("count: expected %0d, actual %0d", want, out_count);
            mismatches <= mismatches + 1;
          end
        end
      end
      pending <= expected_counts.size();
    end
  end

endmodule

// ===== test/partition_count_max_part_core_tb.sv =====
// ----------------------------------------------------------------------------
// partition_count_max_part_core_tb
// stimulus and verdict for the bounded-part partition counter
// ----------------------------------------------------------------------------
// A directed set covers zero totals and limits, limits above the total,
// full-size items and alternating bit patterns. A random set follows, mostly
// small totals with a few at full range, first with no idling and then with
// random gaps on the sender and random stalls on the receiver. A checker
// beside the block predicts every count and compares it.
// ----------------------------------------------------------------------------
module partition_count_max_part_core_tb;
  import pcmp_pkg::*;

  // the limit must exceed the length of a full-size item, the longest one
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int RANDOM_ITEMS   = 82;
  localparam int QUIET_ITEMS    = 30;
  localparam int IDLE_PCT       = 37;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [IN_W-1:0]    in_total = '0;
  logic [IN_W-1:0]    in_max_part = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COUNT_W-1:0] out_count;

  int mismatches;
  int pending;
  int checked;
  int items_sent = 0;
  int idle_cycles = 0;
  bit idling_on = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  partition_count_max_part_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_total    (in_total),
    .in_max_part (in_max_part),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_count   (out_count)
  );

  pcmp_count_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_total    (in_total),
    .in_max_part (in_max_part),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_count   (out_count),
    .mismatches  (mismatches),
    .pending     (pending),
    .checked     (checked)
  );

  // receiver stalls at random while idling is on, never during reset
  always @(posedge clk) begin
    out_stall <= rst_n && idling_on && ($urandom_range(99) < IDLE_PCT);
  end

  // watchdog: cycles in a row with no item accepted on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one item, with random gaps ahead of it, and hold it until accepted
  task automatic send_item(input logic [IN_W-1:0] total, input logic [IN_W-1:0] max_part);
    while (idling_on && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_total    <= total;
    in_max_part <= max_part;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // lower valid and hold off until every expected count has come back
  task automatic drain_counts();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [IN_W-1:0] t;
    logic [IN_W-1:0] m;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero limit, zero total, limit above total, full size, bit patterns
    send_item(7'd0,   7'd0);
    send_item(7'd0,   7'd127);
    send_item(7'd5,   7'd0);
    send_item(7'd127, 7'd0);
    send_item(7'd1,   7'd0);
    send_item(7'd1,   7'd1);
    send_item(7'd2,   7'd1);
    send_item(7'd10,  7'd127);
    send_item(7'd10,  7'd10);
    send_item(7'd10,  7'd3);
    send_item(7'd127, 7'd1);
    send_item(7'd127, 7'd2);
    send_item(7'd127, 7'd127);
    send_item(7'd85,  7'd42);
    send_item(7'd42,  7'd85);
    send_item(7'd100, 7'd127);
    send_item(7'd64,  7'd64);
    send_item(7'd3,   7'd2);

    // hold the sender until the block has returned every count
    drain_counts();

    // random: a quiet stretch first, then gaps and stalls
    idling_on = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == QUIET_ITEMS) idling_on = 1'b1;
      if ($urandom_range(9) == 0) begin
        // occasional full-range item, costly so kept rare
        t = IN_W'($urandom);
        m = IN_W'($urandom);
      end else begin
        t = IN_W'($urandom_range(24));
        m = IN_W'($urandom_range(30));
      end
      send_item(t, m);
    end

    drain_counts();
    // a short wait to catch any stray result
    repeat (50) @(posedge clk);

    $display("sent %0d items (directed edge cases then random), %0d counts checked",
             items_sent, checked);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
